FILE: rtl/core/qtok_pkg.sv
// ----------------------------------------------------------------------------
// qtok_pkg
// Shared types and character constants for the quote-aware tokenizer.
// ----------------------------------------------------------------------------
package qtok_pkg;

	// fixed characters
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	// open quote codes
	typedef enum logic [1:0] {
		QUOTE_NONE   = 2'd0,
		QUOTE_SINGLE = 2'd1,
		QUOTE_DOUBLE = 2'd2,
		QUOTE_SPARE  = 2'd3
	} quote_t;

	// one input item
	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_string;
	} item_t;

	// one result item
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       token_end;
	} result_t;

	// handoff from the input register to the decode stage
	typedef struct packed {
		logic  valid;
		item_t item;
	} stage_t;

	// decode stage output towards the result register
	typedef struct packed {
		logic    advance;
		logic    has_result;
		result_t result;
	} decode_t;

	function automatic logic is_separator(input logic [7:0] b);
		return (b == CH_COMMA) || (b == CH_SPACE);
	endfunction

endpackage

FILE: rtl/core/qtok_in_if.sv
// ----------------------------------------------------------------------------
// qtok_in_if
// Byte channel into the tokenizer: valid, ready and one input item.
// ----------------------------------------------------------------------------
interface qtok_in_if
	import qtok_pkg::*;
();
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_string;

	modport source (output valid, output in_byte, output end_of_string, input ready);
	modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

FILE: rtl/core/qtok_out_if.sv
// ----------------------------------------------------------------------------
// qtok_out_if
// Token channel out of the tokenizer: valid, ready and one result item.
// ----------------------------------------------------------------------------
interface qtok_out_if
	import qtok_pkg::*;
();
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       token_end;

	modport source (output valid, output out_byte, output byte_valid, output token_end,
		input ready);
	modport sink   (input valid, input out_byte, input byte_valid, input token_end,
		output ready);
endinterface

FILE: rtl/core/qtok_in_reg.sv
// ----------------------------------------------------------------------------
// qtok_in_reg
// Input register: holds one accepted byte until the decode stage consumes it.
// ----------------------------------------------------------------------------
module qtok_in_reg
	import qtok_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  item_t  in_item,
	input  logic   advance,
	output stage_t stage
);

	logic  valid_s1;
	item_t item_s1;

	// take a new byte when empty or when the held one moves on
	assign in_ready = !valid_s1 || advance;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.item  = item_s1;

endmodule

FILE: rtl/core/qtok_decode.sv
// ----------------------------------------------------------------------------
// qtok_decode
// Tokenizer state and per-byte decode: quote tracking, escapes, token ends.
// ----------------------------------------------------------------------------
module qtok_decode
	import qtok_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  stage_t  stage,
	input  logic    out_free,
	output decode_t dec
);

	quote_t quote_q, quote_d;
	logic   esc_q, esc_d;
	logic   intok_q, intok_d;
	logic   keep, ends;
	logic   sep, closes;
	logic [7:0] b;

	assign b      = stage.item.in_byte;
	assign sep    = is_separator(b);
	assign closes = ((quote_q == QUOTE_SINGLE) && (b == CH_SQUOTE)) ||
		((quote_q == QUOTE_DOUBLE) && (b == CH_DQUOTE));

	// next state and result for the held byte
	always_comb begin
		quote_d = quote_q;
		esc_d   = esc_q;
		intok_d = intok_q;
		keep    = 1'b0;
		ends    = 1'b0;
		if (intok_q || (quote_q != QUOTE_NONE) || !sep) begin
			intok_d = 1'b1;
			if (quote_q == QUOTE_NONE) begin
				priority if (b == CH_SQUOTE) begin
					quote_d = QUOTE_SINGLE;
				end else if (b == CH_DQUOTE) begin
					quote_d = QUOTE_DOUBLE;
				end else if (sep) begin
					ends    = 1'b1;
					intok_d = 1'b0;
				end else begin
					keep = 1'b1;
				end
			end else begin
				priority if (esc_q) begin
					esc_d = 1'b0;
					keep  = 1'b1;
				end else if (b == CH_BSLASH) begin
					esc_d = 1'b1;
				end else if (closes) begin
					quote_d = QUOTE_NONE;
				end else begin
					keep = 1'b1;
				end
			end
		end
		// end of string closes everything
		if (stage.item.end_of_string) begin
			if (intok_d) begin
				ends = 1'b1;
			end
			quote_d = QUOTE_NONE;
			esc_d   = 1'b0;
			intok_d = 1'b0;
		end
	end

	assign dec.advance           = stage.valid && out_free;
	assign dec.has_result        = keep || ends;
	assign dec.result.out_byte   = keep ? b : 8'h00;
	assign dec.result.byte_valid = keep;
	assign dec.result.token_end  = ends;

	// state update once per consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_q <= QUOTE_NONE;
			esc_q   <= 1'b0;
			intok_q <= 1'b0;
		end else if (dec.advance) begin
			quote_q <= quote_d;
			esc_q   <= esc_d;
			intok_q <= intok_d;
		end
	end

	// a pending escape only exists inside quotes
	a_esc_in_quote: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> (quote_q != QUOTE_NONE))
		else $error("escape pending outside quotes");

	// state is back at reset after the last byte of a string
	a_eos_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(dec.advance && stage.item.end_of_string) |=>
		(quote_q == QUOTE_NONE) && !esc_q && !intok_q)
		else $error("state not cleared at end of string");

	// an open quote always belongs to a token
	a_quote_in_token: assert property (@(posedge clk) disable iff (!arst_n)
		(quote_q != QUOTE_NONE) |-> intok_q)
		else $error("quote open outside a token");

endmodule

FILE: rtl/core/qtok_out_reg.sv
// ----------------------------------------------------------------------------
// qtok_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module qtok_out_reg
	import qtok_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  decode_t dec,
	output logic    out_free,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_result
);

	logic    valid_q;
	result_t result_q;
	logic    load;

	assign out_free = !valid_q || out_ready;
	assign load     = dec.advance && dec.has_result;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= load;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= dec.result;
		end
	end

	assign out_valid  = valid_q;
	assign out_result = result_q;

endmodule

FILE: rtl/core/quote_aware_tokenizer_unit.sv
// A byte accepted into the input register is decoded there and its result is
// registered in the result register, from which the result transfer happens.
// Throughput: one byte per cycle unless tokens.ready stalls the output;
// the decode is one short stage between the input and result registers.
// A byte that gives no result leaves the output untouched.
// Reset (arst_n low, asynchronous) empties both registers and clears the
// quote, escape and token state.
// ----------------------------------------------------------------------------
// quote_aware_tokenizer_unit
// Splits a byte stream into tokens with quote and escape handling.
// ----------------------------------------------------------------------------
module quote_aware_tokenizer_unit
	import qtok_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	qtok_in_if.sink   stream,
	qtok_out_if.source tokens
);

	item_t   in_item;
	stage_t  stage;
	decode_t dec;
	logic    out_free;
	result_t out_result;

	assign in_item.in_byte       = stream.in_byte;
	assign in_item.end_of_string = stream.end_of_string;

	// input register
	qtok_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (stream.valid),
		.in_ready (stream.ready),
		.in_item  (in_item),
		.advance  (dec.advance),
		.stage    (stage)
	);

	// state and decode
	qtok_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.stage    (stage),
		.out_free (out_free),
		.dec      (dec)
	);

	// result register
	qtok_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.dec        (dec),
		.out_free   (out_free),
		.out_valid  (tokens.valid),
		.out_ready  (tokens.ready),
		.out_result (out_result)
	);

	assign tokens.out_byte   = out_result.out_byte;
	assign tokens.byte_valid = out_result.byte_valid;
	assign tokens.token_end  = out_result.token_end;

endmodule
